FILE: hdl/ptq_pkg.sv
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared codes and types for the priority task queue: operation kinds,
// result status codes and the decoded operation flags.
// ----------------------------------------------------------------------------
`default_nettype none

package ptq_pkg;

    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_POP    = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

    typedef struct packed {
        logic insert;
        logic remove;
        logic pop;
        logic clear;
    } t_op;

    localparam int STATUS_BITS = 2;
    localparam int OP_BITS     = $bits(t_op);

endpackage

`default_nettype wire

FILE: hdl/priority_task_queue.sv
// ----------------------------------------------------------------------------
// priority_task_queue
// Bounded task queue kept sorted by signed priority, highest at the head.
// A request beat passes the command queue, the compare registers and the
// result queue on its way to the ports. A new operation is taken only after
// the slot row has shifted for the last one and the result queue has room.
// Reset: synchronous active low; empties the queue and both beat queues.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_task_queue #(
    parameter int DEPTH         = 16,
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic [1:0]                      i_kind,
    input  wire logic signed [PRIORITY_BITS-1:0] i_priority_req,
    input  wire logic [ID_BITS-1:0]              i_task_id,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic [1:0]                           o_status,
    output logic [ID_BITS-1:0]                   o_head_id,
    output logic signed [PRIORITY_BITS-1:0]      o_head_priority,
    output logic [$clog2(DEPTH+1)-1:0]           o_entry_count
);

    logic                            w_cmd_valid;
    logic                            w_cmd_take;
    ptq_pkg::t_op                    w_cmd_op;
    logic [ID_BITS-1:0]              w_cmd_id;
    logic signed [PRIORITY_BITS-1:0] w_cmd_pri;

    ptq_front #(
        .ID_BITS       (ID_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_kind         (i_kind),
        .i_priority_req (i_priority_req),
        .i_task_id      (i_task_id),
        .o_cmd_valid    (w_cmd_valid),
        .i_cmd_take     (w_cmd_take),
        .o_cmd_op       (w_cmd_op),
        .o_cmd_id       (w_cmd_id),
        .o_cmd_pri      (w_cmd_pri)
    );

    ptq_back #(
        .DEPTH         (DEPTH),
        .ID_BITS       (ID_BITS),
        .PRIORITY_BITS (PRIORITY_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (w_cmd_valid),
        .o_cmd_take      (w_cmd_take),
        .i_cmd_op        (w_cmd_op),
        .i_cmd_id        (w_cmd_id),
        .i_cmd_pri       (w_cmd_pri),
        .o_empty         (empty),
        .i_pop           (pop),
        .o_status        (o_status),
        .o_head_id       (o_head_id),
        .o_head_priority (o_head_priority),
        .o_entry_count   (o_entry_count)
    );

endmodule

`default_nettype wire

FILE: hdl/ptq_fifo.sv
// ----------------------------------------------------------------------------
// ptq_fifo
// Two-entry register queue with registered storage; decouples producer and
// consumer so that each side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wptr <= !r_wptr;
            end
            if (w_rd) begin
                r_rptr <= !r_rptr;
            end
            priority if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/ptq_front.sv
// ----------------------------------------------------------------------------
// ptq_front
// Input side: accepts request beats, decodes the operation kind into flags
// and queues the decoded command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_front #(
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_push,
    output logic                                 o_full,
    input  wire logic [1:0]                      i_kind,
    input  wire logic signed [PRIORITY_BITS-1:0] i_priority_req,
    input  wire logic [ID_BITS-1:0]              i_task_id,
    output logic                                 o_cmd_valid,
    input  wire logic                            i_cmd_take,
    output ptq_pkg::t_op                         o_cmd_op,
    output logic [ID_BITS-1:0]                   o_cmd_id,
    output logic signed [PRIORITY_BITS-1:0]      o_cmd_pri
);

    localparam int CMD_BITS = ptq_pkg::OP_BITS + ID_BITS + PRIORITY_BITS;

    ptq_pkg::t_op        w_op;
    logic [CMD_BITS-1:0] w_wr_data;
    logic [CMD_BITS-1:0] w_rd_data;

    always_comb begin
        w_op = '0;
        unique case (ptq_pkg::t_kind'(i_kind))
            ptq_pkg::KIND_INSERT: w_op.insert = 1'b1;
            ptq_pkg::KIND_REMOVE: w_op.remove = 1'b1;
            ptq_pkg::KIND_POP:    w_op.pop    = 1'b1;
            ptq_pkg::KIND_CLEAR:  w_op.clear  = 1'b1;
            default:              w_op        = '0;
        endcase
    end

    assign w_wr_data = {w_op, i_task_id, i_priority_req};

    ptq_fifo #(
        .WIDTH (CMD_BITS)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_wr_data),
        .o_full  (o_full),
        .i_pop   (i_cmd_take),
        .o_valid (o_cmd_valid),
        .o_data  (w_rd_data)
    );

    assign o_cmd_op  = ptq_pkg::t_op'(w_rd_data[CMD_BITS-1 -: ptq_pkg::OP_BITS]);
    assign o_cmd_id  = w_rd_data[PRIORITY_BITS +: ID_BITS];
    assign o_cmd_pri = $signed(w_rd_data[PRIORITY_BITS-1:0]);

endmodule

`default_nettype wire

FILE: hdl/ptq_back.sv
// ----------------------------------------------------------------------------
// ptq_back
// Execution side: a row of slot cells kept sorted by priority. The command
// is compared against every slot as it is taken; in the cycle after that the
// cells shift and the result beat is queued.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_back #(
    parameter int DEPTH         = 16,
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cmd_valid,
    output logic                                 o_cmd_take,
    input  wire ptq_pkg::t_op                    i_cmd_op,
    input  wire logic [ID_BITS-1:0]              i_cmd_id,
    input  wire logic signed [PRIORITY_BITS-1:0] i_cmd_pri,
    output logic                                 o_empty,
    input  wire logic                            i_pop,
    output logic [1:0]                           o_status,
    output logic [ID_BITS-1:0]                   o_head_id,
    output logic signed [PRIORITY_BITS-1:0]      o_head_priority,
    output logic [$clog2(DEPTH+1)-1:0]           o_entry_count
);

    localparam int CW       = $clog2(DEPTH+1);
    localparam int LEVELS   = $clog2(DEPTH);
    localparam int RSP_BITS = ptq_pkg::STATUS_BITS + ID_BITS + PRIORITY_BITS + CW;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                           r_state;
    logic [ID_BITS-1:0]               r_id  [DEPTH];
    logic signed [PRIORITY_BITS-1:0]  r_pri [DEPTH];
    logic [ID_BITS-1:0]               n_id  [DEPTH];
    logic signed [PRIORITY_BITS-1:0]  n_pri [DEPTH];
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    ptq_pkg::t_op                     r_op;
    logic [ID_BITS-1:0]               r_cmd_id;
    logic signed [PRIORITY_BITS-1:0]  r_cmd_pri;
    logic [DEPTH-1:0]                 r_gt;
    logic [DEPTH-1:0]                 r_eq;
    logic [DEPTH-1:0]                 r_match;
    logic [DEPTH-1:0]                 w_gt;
    logic [DEPTH-1:0]                 w_eq;
    logic [DEPTH-1:0]                 w_match;
    logic [DEPTH-1:0]                 w_keep;
    logic [DEPTH-1:0]                 w_pre [LEVELS+1];
    logic [DEPTH-1:0]                 w_hit;
    logic                             w_found;
    logic                             w_is_full;
    logic                             w_is_empty;
    logic                             w_do_insert;
    logic                             w_do_remove;
    logic                             w_do_pop;
    ptq_pkg::t_status                 w_status;
    logic [ID_BITS-1:0]               w_hid;
    logic signed [PRIORITY_BITS-1:0]  w_hpri;
    logic                             w_rsp_full;
    logic                             w_rsp_push;
    logic [RSP_BITS-1:0]              w_rsp_wr;
    logic [RSP_BITS-1:0]              w_rsp_rd;
    logic                             w_rsp_valid;

    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid && !w_rsp_full;
    assign w_rsp_push = (r_state == S_EXEC);

    // compare and shift cells
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                            w_valid;
            logic                            w_keep_prev;
            logic [ID_BITS-1:0]              w_prev_id;
            logic signed [PRIORITY_BITS-1:0] w_prev_pri;
            logic [ID_BITS-1:0]              w_next_id;
            logic signed [PRIORITY_BITS-1:0] w_next_pri;

            assign w_valid    = (CW'(g) < r_count);
            assign w_gt[g]    = w_valid && (r_pri[g] > i_cmd_pri);
            assign w_eq[g]    = w_valid && (r_pri[g] == i_cmd_pri);
            assign w_match[g] = w_valid && (r_id[g] == i_cmd_id);

            if (g == 0) begin : g_first
                assign w_keep_prev = 1'b1;
                assign w_prev_id   = r_cmd_id;
                assign w_prev_pri  = r_cmd_pri;
                assign w_keep[g]   = r_gt[g] | r_eq[g];
            end else begin : g_rest
                assign w_keep_prev = w_keep[g-1];
                assign w_prev_id   = r_id[g-1];
                assign w_prev_pri  = r_pri[g-1];
                assign w_keep[g]   = r_gt[g] | (r_eq[g] & r_gt[g-1]);
            end

            if (g == DEPTH-1) begin : g_last
                assign w_next_id  = r_id[g];
                assign w_next_pri = r_pri[g];
            end else begin : g_inner
                assign w_next_id  = r_id[g+1];
                assign w_next_pri = r_pri[g+1];
            end

            always_comb begin
                n_id[g]  = r_id[g];
                n_pri[g] = r_pri[g];
                priority if (w_do_insert) begin
                    if (!w_keep[g]) begin
                        if (w_keep_prev) begin
                            n_id[g]  = r_cmd_id;
                            n_pri[g] = r_cmd_pri;
                        end else begin
                            n_id[g]  = w_prev_id;
                            n_pri[g] = w_prev_pri;
                        end
                    end
                end else if (w_do_pop || (w_do_remove && w_hit[g])) begin
                    n_id[g]  = w_next_id;
                    n_pri[g] = w_next_pri;
                end
            end
        end
    endgenerate

    // prefix or of match flags, first hit and everything after it
    assign w_pre[0] = r_match;
    generate
        for (g = 0; g < LEVELS; g++) begin : g_pre
            assign w_pre[g+1] = w_pre[g] | (w_pre[g] << (1 << g));
        end
    endgenerate
    assign w_hit   = w_pre[LEVELS];
    assign w_found = w_hit[DEPTH-1];

    assign w_is_full   = (r_count == CW'(DEPTH));
    assign w_is_empty  = (r_count == '0);
    assign w_do_insert = w_rsp_push && r_op.insert && !w_is_full;
    assign w_do_remove = w_rsp_push && r_op.remove && w_found;
    assign w_do_pop    = w_rsp_push && r_op.pop && !w_is_empty;

    always_comb begin
        w_status = ptq_pkg::ST_OK;
        w_hid    = '0;
        w_hpri   = '0;
        n_count  = r_count;
        priority if (r_op.insert) begin
            if (w_is_full) begin
                w_status = ptq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CW'(1);
            end
        end else if (r_op.remove) begin
            if (w_found) begin
                n_count = r_count - CW'(1);
            end else begin
                w_status = ptq_pkg::ST_NOT_FOUND;
            end
        end else if (r_op.pop) begin
            if (w_is_empty) begin
                w_status = ptq_pkg::ST_EMPTY;
            end else begin
                w_hid   = r_id[0];
                w_hpri  = r_pri[0];
                n_count = r_count - CW'(1);
            end
        end else begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_count <= n_count;
                end
                default: r_state <= S_IDLE;
            endcase
        end
        if (o_cmd_take) begin
            r_op      <= i_cmd_op;
            r_cmd_id  <= i_cmd_id;
            r_cmd_pri <= i_cmd_pri;
            r_gt      <= w_gt;
            r_eq      <= w_eq;
            r_match   <= w_match;
        end
        for (int i = 0; i < DEPTH; i++) begin
            r_id[i]  <= n_id[i];
            r_pri[i] <= n_pri[i];
        end
    end

    assign w_rsp_wr = {w_status, w_hid, w_hpri, n_count};

    ptq_fifo #(
        .WIDTH (RSP_BITS)
    ) u_rsp_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rsp_push),
        .i_data  (w_rsp_wr),
        .o_full  (w_rsp_full),
        .i_pop   (i_pop),
        .o_valid (w_rsp_valid),
        .o_data  (w_rsp_rd)
    );

    assign o_empty         = !w_rsp_valid;
    assign o_status        = w_rsp_rd[RSP_BITS-1 -: ptq_pkg::STATUS_BITS];
    assign o_head_id       = w_rsp_rd[CW+PRIORITY_BITS +: ID_BITS];
    assign o_head_priority = $signed(w_rsp_rd[CW +: PRIORITY_BITS]);
    assign o_entry_count   = w_rsp_rd[CW-1:0];

endmodule

`default_nettype wire

FILE: hdl/ptq_checker.sv
// ----------------------------------------------------------------------------
// ptq_checker
// Port-level checks on the priority task queue result beats and reset state,
// bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ptq_checker #(
    parameter int DEPTH         = 16,
    parameter int ID_BITS       = 16,
    parameter int PRIORITY_BITS = 16
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            full,
    input wire logic                            empty,
    input wire logic                            pop,
    input wire logic [1:0]                      o_status,
    input wire logic [ID_BITS-1:0]              o_head_id,
    input wire logic signed [PRIORITY_BITS-1:0] o_head_priority,
    input wire logic [$clog2(DEPTH+1)-1:0]      o_entry_count
);

    localparam int CW = $clog2(DEPTH+1);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("queues not empty after reset");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_entry_count <= CW'(DEPTH)))
        else $error("entry count above depth");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == ptq_pkg::ST_FULL)) |-> (o_entry_count == CW'(DEPTH)))
        else $error("full status with room left");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == ptq_pkg::ST_EMPTY)) |->
            ((o_entry_count == '0) && (o_head_id == '0) && (o_head_priority == '0)))
        else $error("empty status with entries or head data");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_head_id)
            && $stable(o_entry_count)))
        else $error("stalled result beat changed");

endmodule

bind priority_task_queue ptq_checker #(
    .DEPTH         (DEPTH),
    .ID_BITS       (ID_BITS),
    .PRIORITY_BITS (PRIORITY_BITS)
) u_ptq_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .full            (full),
    .empty           (empty),
    .pop             (pop),
    .o_status        (o_status),
    .o_head_id       (o_head_id),
    .o_head_priority (o_head_priority),
    .o_entry_count   (o_entry_count)
);

`default_nettype wire
